// File: hw/rtl/tlmh_pkg.sv
package tlmh_pkg;

   localparam int TIMER_BITS_DEF = 18;

   localparam int CFG_W     = 16;
   localparam int CFG_IDX_W = 3;
   localparam int RX_W      = 3;
   localparam int TX_W      = 3;
   localparam int MODE_W    = 4;

   // register indexes on the csr port
   localparam logic [CFG_IDX_W-1:0] CSR_WAIT_SET      = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CSR_GREEN         = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CSR_YELLOW        = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CSR_RED           = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CSR_REPLY_TIMEOUT = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CSR_BLINK         = 3'd5;

   localparam logic [CFG_W-1:0] WAIT_SET_RST      = 16'd1000;
   localparam logic [CFG_W-1:0] GREEN_RST         = 16'd5000;
   localparam logic [CFG_W-1:0] YELLOW_RST        = 16'd2000;
   localparam logic [CFG_W-1:0] RED_RST           = 16'd5000;
   localparam logic [CFG_W-1:0] REPLY_TIMEOUT_RST = 16'd500;
   localparam logic [CFG_W-1:0] BLINK_RST         = 16'd500;

   typedef enum logic [MODE_W-1:0] {
      MODE_START     = 4'd0,
      MODE_IDLE      = 4'd1,
      MODE_LISTEN    = 4'd2,
      MODE_SET_RED   = 4'd3,
      MODE_RED       = 4'd4,
      MODE_GREEN     = 4'd5,
      MODE_YELLOW    = 4'd6,
      MODE_BLINK_ON  = 4'd7,
      MODE_BLINK_OFF = 4'd8
   } mode_type;

   localparam logic [RX_W-1:0] RX_NONE = 3'd0;
   localparam logic [RX_W-1:0] RX_PING = 3'd1;
   localparam logic [RX_W-1:0] RX_ACK  = 3'd2;
   localparam logic [RX_W-1:0] RX_NACK = 3'd3;

   localparam logic [TX_W-1:0] TX_NONE  = 3'd0;
   localparam logic [TX_W-1:0] TX_PING  = 3'd1;
   localparam logic [TX_W-1:0] TX_GO    = 3'd2;
   localparam logic [TX_W-1:0] TX_SLOW  = 3'd3;
   localparam logic [TX_W-1:0] TX_STOP  = 3'd4;
   localparam logic [TX_W-1:0] TX_CHECK = 3'd5;

   // lamp vector bit positions
   localparam int LAMP_RED = 0;
   localparam int LAMP_YEL = 1;
   localparam int LAMP_GRN = 2;

endpackage

// File: hw/rtl/traffic_light_master_handshake_top.sv
// The response of a request is registered at the same edge that accepts it.
// Throughput: one request per cycle while the response side does not stall; the response
// register lets a new request in while the current response is taken in the same cycle.
// The mode machine and elapsed counter update at request accept, from one pass of logic.
// Reset (synchronous, active high): mode start, timer and lamps cleared, registers
// back to their defaults, no response pending.
module traffic_light_master_handshake_top #(
   parameter int TIMER_BITS = tlmh_pkg::TIMER_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_ms_tick,
   input  logic [tlmh_pkg::RX_W-1:0]     req_rx_msg,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tlmh_pkg::TX_W-1:0]     rsp_tx_msg,
   output logic                          rsp_tx_extra_nack,
   output logic                          rsp_red_lamp,
   output logic                          rsp_yellow_lamp,
   output logic                          rsp_green_lamp,
   output logic [tlmh_pkg::MODE_W-1:0]   rsp_light_mode,
   input  logic                          csr_we,
   input  logic [tlmh_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [tlmh_pkg::CFG_W-1:0]    csr_wdata
);

   logic [tlmh_pkg::CFG_W-1:0] wait_set_ff, green_ff, yellow_ff, red_ff, timeout_ff, blink_ff;

   tlmh_pkg::mode_type       mode_ff, mode_in;
   logic                     red_phase_ff, red_phase_in;
   logic [TIMER_BITS-1:0]    elapsed_ff, elapsed_in;
   logic [2:0]               lamps_ff, lamps_in;

   logic                     rsp_valid_ff;
   logic [tlmh_pkg::TX_W-1:0] rsp_tx_ff, tx_in;
   logic                     rsp_extra_ff, extra_in;
   logic [2:0]               rsp_lamps_ff;
   logic [tlmh_pkg::MODE_W-1:0] rsp_mode_ff;

   logic                     req_accept;
   logic [TIMER_BITS-1:0]    tick_elapsed;
   logic [TIMER_BITS-1:0]    wait_set_x, yellow_x, red_x, timeout_x, blink_x;
   logic [TIMER_BITS-1:0]    set_limit_x, red_wait_x, red_limit_x, green_limit_x, yel_limit_x;
   logic [tlmh_pkg::CFG_W-1:0] red_wait;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // counts first, saturating
   assign tick_elapsed = (req_ms_tick && elapsed_ff != '1) ? elapsed_ff + 1'b1 : elapsed_ff;

   assign red_wait = red_phase_ff ? yellow_ff : green_ff;

   assign wait_set_x    = TIMER_BITS'(wait_set_ff);
   assign yellow_x      = TIMER_BITS'(yellow_ff);
   assign red_x         = TIMER_BITS'(red_ff);
   assign timeout_x     = TIMER_BITS'(timeout_ff);
   assign blink_x       = TIMER_BITS'(blink_ff);
   assign red_wait_x    = TIMER_BITS'(red_wait);
   // 17-bit sums, zero extended to the timer width
   assign set_limit_x   = TIMER_BITS'({1'b0, wait_set_ff} + {1'b0, timeout_ff});
   assign red_limit_x   = TIMER_BITS'({1'b0, red_wait} + {1'b0, timeout_ff});
   assign green_limit_x = TIMER_BITS'({1'b0, red_ff} + {1'b0, green_ff});
   assign yel_limit_x   = TIMER_BITS'({1'b0, red_ff} + {1'b0, yellow_ff});

   always_comb begin
      mode_in      = mode_ff;
      red_phase_in = red_phase_ff;
      elapsed_in   = tick_elapsed;
      lamps_in     = lamps_ff;
      tx_in        = tlmh_pkg::TX_NONE;
      extra_in     = 1'b0;
      case (mode_ff)
         tlmh_pkg::MODE_IDLE: begin
            tx_in   = tlmh_pkg::TX_PING;
            mode_in = tlmh_pkg::MODE_LISTEN;
         end
         tlmh_pkg::MODE_LISTEN: begin
            if (req_rx_msg != tlmh_pkg::RX_NONE) begin
               if (req_rx_msg == tlmh_pkg::RX_PING) begin
                  elapsed_in                   = '0;
                  lamps_in[tlmh_pkg::LAMP_RED] = 1'b1;
                  mode_in                      = tlmh_pkg::MODE_SET_RED;
               end
            end else if (tick_elapsed > timeout_x) begin
               elapsed_in = '0;
               mode_in    = tlmh_pkg::MODE_IDLE;
            end
         end
         tlmh_pkg::MODE_SET_RED: begin
            if (tick_elapsed > wait_set_x) begin
               tx_in = tlmh_pkg::TX_GO;
               if (req_rx_msg != tlmh_pkg::RX_NONE) begin
                  if (req_rx_msg == tlmh_pkg::RX_ACK) begin
                     elapsed_in   = '0;
                     red_phase_in = 1'b0;
                     mode_in      = tlmh_pkg::MODE_RED;
                  end else if (req_rx_msg == tlmh_pkg::RX_NACK) begin
                     elapsed_in = '0;
                     lamps_in   = '0;
                     mode_in    = tlmh_pkg::MODE_BLINK_ON;
                  end
               end else if (tick_elapsed > set_limit_x) begin
                  elapsed_in = '0;
                  lamps_in   = '0;
                  mode_in    = tlmh_pkg::MODE_BLINK_ON;
               end
            end
         end
         tlmh_pkg::MODE_RED: begin
            if (tick_elapsed > red_wait_x) begin
               tx_in = red_phase_ff ? tlmh_pkg::TX_STOP : tlmh_pkg::TX_SLOW;
               if (req_rx_msg != tlmh_pkg::RX_NONE) begin
                  if (req_rx_msg == tlmh_pkg::RX_ACK) begin
                     elapsed_in = '0;
                     if (red_phase_ff) begin
                        red_phase_in                 = 1'b0;
                        lamps_in[tlmh_pkg::LAMP_RED] = 1'b0;
                        lamps_in[tlmh_pkg::LAMP_GRN] = 1'b1;
                        mode_in                      = tlmh_pkg::MODE_GREEN;
                     end else begin
                        red_phase_in = 1'b1;
                     end
                  end else if (req_rx_msg == tlmh_pkg::RX_NACK) begin
                     // sub-phase kept on nack
                     elapsed_in = '0;
                     lamps_in   = '0;
                     mode_in    = tlmh_pkg::MODE_BLINK_ON;
                  end
               end else if (tick_elapsed > red_limit_x) begin
                  red_phase_in = 1'b0;
                  elapsed_in   = '0;
                  lamps_in     = '0;
                  mode_in      = tlmh_pkg::MODE_BLINK_ON;
               end
            end
         end
         tlmh_pkg::MODE_GREEN: begin
            if (tick_elapsed > red_x) begin
               tx_in = tlmh_pkg::TX_CHECK;
               if (req_rx_msg != tlmh_pkg::RX_NONE) begin
                  if (req_rx_msg == tlmh_pkg::RX_ACK) begin
                     // early ack is dropped
                     if (tick_elapsed > green_limit_x) begin
                        elapsed_in                   = '0;
                        lamps_in[tlmh_pkg::LAMP_GRN] = 1'b0;
                        lamps_in[tlmh_pkg::LAMP_YEL] = 1'b1;
                        mode_in                      = tlmh_pkg::MODE_YELLOW;
                     end
                  end else if (req_rx_msg == tlmh_pkg::RX_NACK) begin
                     elapsed_in = '0;
                     lamps_in   = '0;
                     mode_in    = tlmh_pkg::MODE_BLINK_ON;
                  end
               end else if (tick_elapsed > green_limit_x) begin
                  elapsed_in = '0;
                  lamps_in   = '0;
                  mode_in    = tlmh_pkg::MODE_BLINK_ON;
               end
            end
         end
         tlmh_pkg::MODE_YELLOW: begin
            tx_in = tlmh_pkg::TX_CHECK;
            if (req_rx_msg != tlmh_pkg::RX_NONE) begin
               if (req_rx_msg == tlmh_pkg::RX_ACK) begin
                  if (tick_elapsed > yellow_x) begin
                     elapsed_in                   = '0;
                     lamps_in[tlmh_pkg::LAMP_YEL] = 1'b0;
                     lamps_in[tlmh_pkg::LAMP_RED] = 1'b1;
                     mode_in                      = tlmh_pkg::MODE_SET_RED;
                  end
               end else if (req_rx_msg == tlmh_pkg::RX_NACK) begin
                  elapsed_in = '0;
                  lamps_in   = '0;
                  mode_in    = tlmh_pkg::MODE_BLINK_ON;
               end
            end else if (tick_elapsed > yel_limit_x) begin
               elapsed_in = '0;
               lamps_in   = '0;
               mode_in    = tlmh_pkg::MODE_BLINK_ON;
            end
         end
         tlmh_pkg::MODE_BLINK_ON,
         tlmh_pkg::MODE_BLINK_OFF: begin
            tx_in = tlmh_pkg::TX_PING;
            if (req_rx_msg != tlmh_pkg::RX_NONE) begin
               if (req_rx_msg == tlmh_pkg::RX_PING) begin
                  elapsed_in = '0;
                  if (mode_ff == tlmh_pkg::MODE_BLINK_ON) begin
                     lamps_in[tlmh_pkg::LAMP_YEL] = 1'b0;
                  end
                  lamps_in[tlmh_pkg::LAMP_RED] = 1'b1;
                  mode_in                      = tlmh_pkg::MODE_SET_RED;
               end
            end else if (tick_elapsed > blink_x) begin
               extra_in   = 1'b1;
               elapsed_in = '0;
               if (mode_ff == tlmh_pkg::MODE_BLINK_ON) begin
                  lamps_in[tlmh_pkg::LAMP_YEL] = 1'b0;
                  mode_in                      = tlmh_pkg::MODE_BLINK_OFF;
               end else begin
                  lamps_in[tlmh_pkg::LAMP_YEL] = 1'b1;
                  mode_in                      = tlmh_pkg::MODE_BLINK_ON;
               end
            end
         end
         default: begin
            lamps_in = '0;
            mode_in  = tlmh_pkg::MODE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_set_ff <= tlmh_pkg::WAIT_SET_RST;
         green_ff    <= tlmh_pkg::GREEN_RST;
         yellow_ff   <= tlmh_pkg::YELLOW_RST;
         red_ff      <= tlmh_pkg::RED_RST;
         timeout_ff  <= tlmh_pkg::REPLY_TIMEOUT_RST;
         blink_ff    <= tlmh_pkg::BLINK_RST;
      end else if (csr_we) begin
         case (csr_index)
            tlmh_pkg::CSR_WAIT_SET:      wait_set_ff <= csr_wdata;
            tlmh_pkg::CSR_GREEN:         green_ff    <= csr_wdata;
            tlmh_pkg::CSR_YELLOW:        yellow_ff   <= csr_wdata;
            tlmh_pkg::CSR_RED:           red_ff      <= csr_wdata;
            tlmh_pkg::CSR_REPLY_TIMEOUT: timeout_ff  <= csr_wdata;
            tlmh_pkg::CSR_BLINK:         blink_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= tlmh_pkg::MODE_START;
         red_phase_ff <= 1'b0;
         elapsed_ff   <= '0;
         lamps_ff     <= '0;
      end else if (req_accept) begin
         mode_ff      <= mode_in;
         red_phase_ff <= red_phase_in;
         elapsed_ff   <= elapsed_in;
         lamps_ff     <= lamps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tx_ff    <= tx_in;
         rsp_extra_ff <= extra_in;
         rsp_lamps_ff <= lamps_in;
         rsp_mode_ff  <= mode_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_msg        = rsp_tx_ff;
   assign rsp_tx_extra_nack = rsp_extra_ff;
   assign rsp_red_lamp      = rsp_lamps_ff[tlmh_pkg::LAMP_RED];
   assign rsp_yellow_lamp   = rsp_lamps_ff[tlmh_pkg::LAMP_YEL];
   assign rsp_green_lamp    = rsp_lamps_ff[tlmh_pkg::LAMP_GRN];
   assign rsp_light_mode    = rsp_mode_ff;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   a_reset_state: assert property (@(posedge clock)
      reset |=> mode_ff == tlmh_pkg::MODE_START && !rsp_valid && lamps_ff == '0)
      else $error("state not cleared by reset");

   a_extra_nack_blink: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_extra_nack |->
         rsp_light_mode == tlmh_pkg::MODE_BLINK_ON ||
         rsp_light_mode == tlmh_pkg::MODE_BLINK_OFF)
      else $error("second nack outside blinking");

   a_green_lamp_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_green_lamp |-> rsp_light_mode == tlmh_pkg::MODE_GREEN)
      else $error("green lamp lit outside green mode");

endmodule

// File: dv/tlmh_checker.sv
`timescale 1ns / 1ps

module tlmh_checker #(
   parameter int TIMER_BITS = tlmh_pkg::TIMER_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_ms_tick,
   input  logic [tlmh_pkg::RX_W-1:0]      req_rx_msg,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [tlmh_pkg::TX_W-1:0]      rsp_tx_msg,
   input  logic                           rsp_tx_extra_nack,
   input  logic                           rsp_red_lamp,
   input  logic                           rsp_yellow_lamp,
   input  logic                           rsp_green_lamp,
   input  logic [tlmh_pkg::MODE_W-1:0]    rsp_light_mode,
   input  logic                           csr_we,
   input  logic [tlmh_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [tlmh_pkg::CFG_W-1:0]     csr_wdata,
   output int                             failures,
   output int                             pending
);

   localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;

   typedef struct packed {
      logic [tlmh_pkg::TX_W-1:0]   tx;
      logic                        extra;
      logic                        red;
      logic                        yel;
      logic                        grn;
      logic [tlmh_pkg::MODE_W-1:0] mode;
   } light_out_type;

   logic [tlmh_pkg::CFG_W-1:0]  set_delay, green_len, yellow_len, red_len, reply_wait, blink_half;
   logic [tlmh_pkg::MODE_W-1:0] mode_q;
   logic                        stop_phase;
   longint unsigned             ms_elapsed;
   logic [2:0]                  lamp_q;
   light_out_type               expected_lights[$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   task automatic flag_light_error(input string field, input int got, input int want);
      $display("light check: %s got %0d want %0d at %0t", field, got, want, $realtime);
      failures++;
   endtask

   function automatic void restore_light();
      set_delay  = tlmh_pkg::WAIT_SET_RST;
      green_len  = tlmh_pkg::GREEN_RST;
      yellow_len = tlmh_pkg::YELLOW_RST;
      red_len    = tlmh_pkg::RED_RST;
      reply_wait = tlmh_pkg::REPLY_TIMEOUT_RST;
      blink_half = tlmh_pkg::BLINK_RST;
      mode_q     = tlmh_pkg::MODE_START;
      stop_phase = 1'b0;
      ms_elapsed = 0;
      lamp_q     = '0;
   endfunction

   function automatic void write_setting(input logic [tlmh_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [tlmh_pkg::CFG_W-1:0] val);
      case (idx)
         tlmh_pkg::CSR_WAIT_SET:      set_delay  = val;
         tlmh_pkg::CSR_GREEN:         green_len  = val;
         tlmh_pkg::CSR_YELLOW:        yellow_len = val;
         tlmh_pkg::CSR_RED:           red_len    = val;
         tlmh_pkg::CSR_REPLY_TIMEOUT: reply_wait = val;
         tlmh_pkg::CSR_BLINK:         blink_half = val;
         default: ;
      endcase
   endfunction

   function automatic void enter_blink();
      ms_elapsed = 0;
      lamp_q     = '0;
      mode_q     = tlmh_pkg::MODE_BLINK_ON;
   endfunction

   // one poll pass: tick first, then the handler of the current mode
   function automatic light_out_type next_light(input logic tick,
                                                input logic [tlmh_pkg::RX_W-1:0] rx);
      light_out_type   res;
      longint unsigned span;
      res.tx    = tlmh_pkg::TX_NONE;
      res.extra = 1'b0;
      if (tick && ms_elapsed < TIMER_MAX)
         ms_elapsed++;
      case (mode_q)
         tlmh_pkg::MODE_IDLE: begin
            res.tx = tlmh_pkg::TX_PING;
            mode_q = tlmh_pkg::MODE_LISTEN;
         end
         tlmh_pkg::MODE_LISTEN: begin
            if (rx == tlmh_pkg::RX_PING) begin
               ms_elapsed = 0;
               lamp_q[tlmh_pkg::LAMP_RED] = 1'b1;
               mode_q = tlmh_pkg::MODE_SET_RED;
            end else if (rx == tlmh_pkg::RX_NONE && ms_elapsed > reply_wait) begin
               ms_elapsed = 0;
               mode_q = tlmh_pkg::MODE_IDLE;
            end
         end
         tlmh_pkg::MODE_SET_RED: begin
            if (ms_elapsed > set_delay) begin
               res.tx = tlmh_pkg::TX_GO;
               if (rx == tlmh_pkg::RX_ACK) begin
                  ms_elapsed = 0;
                  stop_phase = 1'b0;
                  mode_q = tlmh_pkg::MODE_RED;
               end else if (rx == tlmh_pkg::RX_NACK) begin
                  enter_blink();
               end else if (rx == tlmh_pkg::RX_NONE &&
                            ms_elapsed > longint'(set_delay) + reply_wait) begin
                  enter_blink();
               end
            end
         end
         tlmh_pkg::MODE_RED: begin
            span = stop_phase ? 64'(yellow_len) : 64'(green_len);
            if (ms_elapsed > span) begin
               res.tx = stop_phase ? tlmh_pkg::TX_STOP : tlmh_pkg::TX_SLOW;
               if (rx == tlmh_pkg::RX_ACK) begin
                  ms_elapsed = 0;
                  if (stop_phase) begin
                     stop_phase = 1'b0;
                     lamp_q[tlmh_pkg::LAMP_RED] = 1'b0;
                     lamp_q[tlmh_pkg::LAMP_GRN] = 1'b1;
                     mode_q = tlmh_pkg::MODE_GREEN;
                  end else begin
                     stop_phase = 1'b1;
                  end
               end else if (rx == tlmh_pkg::RX_NACK) begin
                  // sub-phase is kept on a nack, cleared on a timeout
                  enter_blink();
               end else if (rx == tlmh_pkg::RX_NONE && ms_elapsed > span + reply_wait) begin
                  stop_phase = 1'b0;
                  enter_blink();
               end
            end
         end
         tlmh_pkg::MODE_GREEN: begin
            if (ms_elapsed > red_len) begin
               res.tx = tlmh_pkg::TX_CHECK;
               if (rx == tlmh_pkg::RX_ACK) begin
                  // an early ack is swallowed
                  if (ms_elapsed > longint'(red_len) + green_len) begin
                     ms_elapsed = 0;
                     lamp_q[tlmh_pkg::LAMP_GRN] = 1'b0;
                     lamp_q[tlmh_pkg::LAMP_YEL] = 1'b1;
                     mode_q = tlmh_pkg::MODE_YELLOW;
                  end
               end else if (rx == tlmh_pkg::RX_NACK) begin
                  enter_blink();
               end else if (rx == tlmh_pkg::RX_NONE &&
                            ms_elapsed > longint'(red_len) + green_len) begin
                  enter_blink();
               end
            end
         end
         tlmh_pkg::MODE_YELLOW: begin
            res.tx = tlmh_pkg::TX_CHECK;
            if (rx == tlmh_pkg::RX_ACK) begin
               if (ms_elapsed > yellow_len) begin
                  ms_elapsed = 0;
                  lamp_q[tlmh_pkg::LAMP_YEL] = 1'b0;
                  lamp_q[tlmh_pkg::LAMP_RED] = 1'b1;
                  mode_q = tlmh_pkg::MODE_SET_RED;
               end
            end else if (rx == tlmh_pkg::RX_NACK) begin
               enter_blink();
            end else if (rx == tlmh_pkg::RX_NONE &&
                         ms_elapsed > longint'(red_len) + yellow_len) begin
               enter_blink();
            end
         end
         tlmh_pkg::MODE_BLINK_ON, tlmh_pkg::MODE_BLINK_OFF: begin
            res.tx = tlmh_pkg::TX_PING;
            if (rx == tlmh_pkg::RX_PING) begin
               ms_elapsed = 0;
               if (mode_q == tlmh_pkg::MODE_BLINK_ON)
                  lamp_q[tlmh_pkg::LAMP_YEL] = 1'b0;
               lamp_q[tlmh_pkg::LAMP_RED] = 1'b1;
               mode_q = tlmh_pkg::MODE_SET_RED;
            end else if (rx == tlmh_pkg::RX_NONE && ms_elapsed > blink_half) begin
               res.extra  = 1'b1;
               ms_elapsed = 0;
               if (mode_q == tlmh_pkg::MODE_BLINK_ON) begin
                  lamp_q[tlmh_pkg::LAMP_YEL] = 1'b0;
                  mode_q = tlmh_pkg::MODE_BLINK_OFF;
               end else begin
                  lamp_q[tlmh_pkg::LAMP_YEL] = 1'b1;
                  mode_q = tlmh_pkg::MODE_BLINK_ON;
               end
            end
         end
         default: begin
            lamp_q = '0;
            mode_q = tlmh_pkg::MODE_IDLE;
         end
      endcase
      res.red  = lamp_q[tlmh_pkg::LAMP_RED];
      res.yel  = lamp_q[tlmh_pkg::LAMP_YEL];
      res.grn  = lamp_q[tlmh_pkg::LAMP_GRN];
      res.mode = mode_q;
      return res;
   endfunction

   always @(posedge clock) begin
      light_out_type want;
      if (reset) begin
         restore_light();
         expected_lights.delete();
      end else begin
         if (csr_we)
            write_setting(csr_index, csr_wdata);
         // a response taken here belongs to an earlier request, so compare first
         if (rsp_valid && !rsp_stall) begin
            if (expected_lights.size() == 0) begin
               flag_light_error("unexpected response, mode", int'(rsp_light_mode), -1);
            end else begin
               want = expected_lights.pop_front();
               if (rsp_tx_msg !== want.tx)
                  flag_light_error("tx_msg", int'(rsp_tx_msg), int'(want.tx));
               if (rsp_tx_extra_nack !== want.extra)
                  flag_light_error("tx_extra_nack", int'(rsp_tx_extra_nack),
                                   int'(want.extra));
               if (rsp_red_lamp !== want.red)
                  flag_light_error("red_lamp", int'(rsp_red_lamp), int'(want.red));
               if (rsp_yellow_lamp !== want.yel)
                  flag_light_error("yellow_lamp", int'(rsp_yellow_lamp), int'(want.yel));
               if (rsp_green_lamp !== want.grn)
                  flag_light_error("green_lamp", int'(rsp_green_lamp), int'(want.grn));
               if (rsp_light_mode !== want.mode)
                  flag_light_error("light_mode", int'(rsp_light_mode), int'(want.mode));
            end
         end
         if (req_valid && !req_stall)
            expected_lights.push_back(next_light(req_ms_tick, req_rx_msg));
      end
      pending = expected_lights.size();
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int QUIET_LIMIT = 2000;

   // line codes the block treats as noise, and register slots it ignores
   localparam logic [tlmh_pkg::RX_W-1:0]      RX_OTHER   = 3'd4;
   localparam logic [tlmh_pkg::RX_W-1:0]      RX_CODE5   = 3'd5;
   localparam logic [tlmh_pkg::RX_W-1:0]      RX_CODE7   = 3'd7;
   localparam logic [tlmh_pkg::CFG_IDX_W-1:0] CSR_SPARE6 = 3'd6;
   localparam logic [tlmh_pkg::CFG_IDX_W-1:0] CSR_SPARE7 = 3'd7;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_ms_tick = 1'b0;
   logic [tlmh_pkg::RX_W-1:0]      req_rx_msg = tlmh_pkg::RX_NONE;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [tlmh_pkg::TX_W-1:0]      rsp_tx_msg;
   logic                           rsp_tx_extra_nack;
   logic                           rsp_red_lamp;
   logic                           rsp_yellow_lamp;
   logic                           rsp_green_lamp;
   logic [tlmh_pkg::MODE_W-1:0]    rsp_light_mode;
   logic                           csr_we = 1'b0;
   logic [tlmh_pkg::CFG_IDX_W-1:0] csr_index = tlmh_pkg::CSR_WAIT_SET;
   logic [tlmh_pkg::CFG_W-1:0]     csr_wdata = '0;

   int                             failures;
   int                             pending;
   bit                             no_idle = 1'b0;
   int unsigned                    rsp_hold = 0;
   int unsigned                    quiet_cycles = 0;
   logic [tlmh_pkg::MODE_W-1:0]    seen_mode = tlmh_pkg::MODE_START;

   always #1 clock = ~clock;

   traffic_light_master_handshake_top dut (.*);

   tlmh_checker checker_i (.*);

   function automatic int unsigned draw_gap();
      return no_idle ? 0 : $urandom_range(0, 19);
   endfunction

   // response side: after each response taken, stall while a random hold counts down
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         rsp_hold <= draw_gap();
      else if (rsp_stall && rsp_hold != 0)
         rsp_hold <= rsp_hold - 1;
      if (rsp_valid && !rsp_stall)
         seen_mode <= rsp_light_mode;
   end

   always @(negedge clock)
      rsp_stall <= (rsp_hold != 0);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // entered and left at a falling edge
   task automatic send_request(input logic tick, input logic [tlmh_pkg::RX_W-1:0] rx);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_ms_tick <= tick;
      req_rx_msg  <= rx;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // mostly the answer a well-behaved slave would give in the last mode seen
   task automatic send_slave_reply();
      logic                      tick;
      logic [tlmh_pkg::RX_W-1:0] rx;
      int unsigned               roll;
      tick = ($urandom_range(0, 9) < 6);
      roll = $urandom_range(0, 19);
      rx   = tlmh_pkg::RX_NONE;
      if (roll < 2) begin
         tick = 1'($urandom_range(0, 1));
         rx   = tlmh_pkg::RX_W'($urandom_range(0, 7));
      end else begin
         case (seen_mode)
            tlmh_pkg::MODE_LISTEN, tlmh_pkg::MODE_BLINK_ON, tlmh_pkg::MODE_BLINK_OFF:
               if (roll < 8) rx = tlmh_pkg::RX_PING;
            tlmh_pkg::MODE_SET_RED, tlmh_pkg::MODE_RED, tlmh_pkg::MODE_GREEN,
            tlmh_pkg::MODE_YELLOW: begin
               if (roll < 11) rx = tlmh_pkg::RX_ACK;
               else if (roll == 11) rx = tlmh_pkg::RX_NACK;
            end
            default: ;
         endcase
      end
      send_request(tick, rx);
   endtask

   task automatic write_reg(input logic [tlmh_pkg::CFG_IDX_W-1:0] idx,
                            input logic [tlmh_pkg::CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic program_lights(input logic [tlmh_pkg::CFG_W-1:0] w,
                                 input logic [tlmh_pkg::CFG_W-1:0] g,
                                 input logic [tlmh_pkg::CFG_W-1:0] y,
                                 input logic [tlmh_pkg::CFG_W-1:0] r,
                                 input logic [tlmh_pkg::CFG_W-1:0] t,
                                 input logic [tlmh_pkg::CFG_W-1:0] b);
      write_reg(tlmh_pkg::CSR_WAIT_SET, w);
      write_reg(tlmh_pkg::CSR_GREEN, g);
      write_reg(tlmh_pkg::CSR_YELLOW, y);
      write_reg(tlmh_pkg::CSR_RED, r);
      write_reg(tlmh_pkg::CSR_REPLY_TIMEOUT, t);
      write_reg(tlmh_pkg::CSR_BLINK, b);
      write_reg($urandom_range(0, 1) ? CSR_SPARE6 : CSR_SPARE7, tlmh_pkg::CFG_W'($urandom));
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // hold off until every request has its response
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset values: start, idle, listen with junk lines, then ping
      send_request(1'b0, tlmh_pkg::RX_NONE);
      send_request(1'b1, tlmh_pkg::RX_PING);
      send_request(1'b0, RX_OTHER);
      send_request(1'b1, RX_CODE7);
      send_request(1'b0, tlmh_pkg::RX_ACK);
      send_request(1'b1, tlmh_pkg::RX_PING);
      send_request(1'b1, tlmh_pkg::RX_ACK);
      settle();

      // all intervals zero: walk the full cycle, then nack and blink
      program_lights('0, '0, '0, '0, '0, '0);
      send_request(1'b0, tlmh_pkg::RX_ACK);
      send_request(1'b1, tlmh_pkg::RX_ACK);
      send_request(1'b1, tlmh_pkg::RX_ACK);
      send_request(1'b1, tlmh_pkg::RX_ACK);
      send_request(1'b1, tlmh_pkg::RX_ACK);
      send_request(1'b1, tlmh_pkg::RX_NACK);
      send_request(1'b1, tlmh_pkg::RX_NONE);
      send_request(1'b1, tlmh_pkg::RX_NONE);
      send_request(1'b0, RX_CODE5);
      send_request(1'b1, tlmh_pkg::RX_PING);
      settle();

      program_lights('1, '1, '1, '1, '1, '1);
      repeat (20) send_slave_reply();
      settle();

      for (int p = 0; p < 7; p++) begin
         program_lights(tlmh_pkg::CFG_W'($urandom_range(0, 5)),
                        tlmh_pkg::CFG_W'($urandom_range(0, 5)),
                        tlmh_pkg::CFG_W'($urandom_range(0, 5)),
                        tlmh_pkg::CFG_W'($urandom_range(0, 5)),
                        tlmh_pkg::CFG_W'($urandom_range(0, 5)),
                        tlmh_pkg::CFG_W'($urandom_range(0, 5)));
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (55) send_slave_reply();
         settle();
      end

      repeat (4) @(negedge clock);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
